// ----- rtl/core/kne_pkg.sv -----
// kne_pkg: shared types and constants of the keypad number entry editor
// no dependencies; imported by every module under rtl/core

package kne_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MINUS_MASK = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ERASE_MASK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UP_MASK    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_MASK  = 3'd5;

	localparam int unsigned KEY_W   = 16;
	localparam int unsigned DIGIT_W = 4;

	// editing modes
	localparam logic MODE_TYPED = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

	// control flags passed from decode to the finishing stage
	typedef struct packed {
		logic clamp_en; // typed mode with a key clicked: clamp to the limits
		logic use_div;  // erase key acts: result is the quotient by ten
		logic neg;      // value was negative (sign of the quotient)
		logic changed;  // any key clicked
	} kne_ctl_t;

endpackage

// ----- rtl/core/kne_cfg_regs.sv -----
// kne_cfg_regs: configuration register file (limits and key masks)
// depends on kne_pkg

module kne_cfg_regs #(
	parameter int VALUE_BITS = 32,
	parameter int CFG_BITS   = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [kne_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_BITS-1:0]            cfg_data,
	output logic signed [VALUE_BITS-1:0]   min_limit,
	output logic signed [VALUE_BITS-1:0]   max_limit,
	output logic [kne_pkg::KEY_W-1:0]      minus_key_mask,
	output logic [kne_pkg::KEY_W-1:0]      erase_key_mask,
	output logic [kne_pkg::KEY_W-1:0]      up_key_mask,
	output logic [kne_pkg::KEY_W-1:0]      down_key_mask
);
	import kne_pkg::*;

	logic signed [VALUE_BITS-1:0] min_q, max_q;
	logic [KEY_W-1:0] minus_q, erase_q, up_q, down_q;
	logic wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= {1'b1, {(VALUE_BITS-1){1'b0}}};
			max_q   <= {1'b0, {(VALUE_BITS-1){1'b1}}};
			minus_q <= '0;
			erase_q <= '0;
			up_q    <= '0;
			down_q  <= '0;
		end else if (wr) begin
			case (cfg_index)
				REG_MIN_LIMIT:  min_q   <= cfg_data[VALUE_BITS-1:0];
				REG_MAX_LIMIT:  max_q   <= cfg_data[VALUE_BITS-1:0];
				REG_MINUS_MASK: minus_q <= cfg_data[KEY_W-1:0];
				REG_ERASE_MASK: erase_q <= cfg_data[KEY_W-1:0];
				REG_UP_MASK:    up_q    <= cfg_data[KEY_W-1:0];
				REG_DOWN_MASK:  down_q  <= cfg_data[KEY_W-1:0];
				default: ;
			endcase
		end
	end

	assign min_limit      = min_q;
	assign max_limit      = max_q;
	assign minus_key_mask = minus_q;
	assign erase_key_mask = erase_q;
	assign up_key_mask    = up_q;
	assign down_key_mask  = down_q;

endmodule

// ----- rtl/core/kne_decode.sv -----
// kne_decode: key decode, candidate value and first half of the divide by ten
// depends on kne_pkg

module kne_decode #(
	parameter int VALUE_BITS = 32,
	parameter int WIDE_BITS  = 37
) (
	input  logic                          mode,
	input  logic [kne_pkg::KEY_W-1:0]     keys,
	input  logic signed [VALUE_BITS-1:0]  value,
	input  logic signed [VALUE_BITS-1:0]  min_limit,
	input  logic signed [VALUE_BITS-1:0]  max_limit,
	input  logic [kne_pkg::KEY_W-1:0]     minus_key_mask,
	input  logic [kne_pkg::KEY_W-1:0]     erase_key_mask,
	input  logic [kne_pkg::KEY_W-1:0]     up_key_mask,
	input  logic [kne_pkg::KEY_W-1:0]     down_key_mask,
	output logic signed [WIDE_BITS-1:0]   cand,
	output logic [VALUE_BITS-1:0]         mag,
	output logic [VALUE_BITS-1:0]         q_est,
	output kne_pkg::kne_ctl_t             ctl
);
	import kne_pkg::*;

	logic any_key, minus_hit, erase_hit, digit_hit, up_hit, down_hit;
	logic [DIGIT_W-1:0] digit;
	logic signed [WIDE_BITS-1:0] v_w, times10, dig_w;

	assign any_key   = |keys;
	assign minus_hit = |(keys & minus_key_mask);
	assign erase_hit = |(keys & erase_key_mask);
	assign up_hit    = |(keys & up_key_mask);
	assign down_hit  = |(keys & down_key_mask);
	assign digit_hit = |keys[DIGIT_MAX:0];

	// lowest clicked digit 1..9 wins, zero only when none of them
	always_comb begin
		digit = '0;
		for (int d = int'(DIGIT_MAX); d >= 1; d--) begin
			if (keys[d])
				digit = DIGIT_W'(d);
		end
	end

	assign v_w     = WIDE_BITS'(value);
	assign times10 = (v_w <<< 3) + (v_w <<< 1);
	assign dig_w   = WIDE_BITS'($signed({1'b0, digit}));

	always_comb begin
		cand = v_w;
		if (any_key) begin
			if (mode == MODE_TYPED) begin
				if (minus_hit)
					cand = -v_w;
				else if (!erase_hit && digit_hit)
					cand = value[VALUE_BITS-1] ? times10 - dig_w : times10 + dig_w;
			end else begin
				if (up_hit && value < max_limit)
					cand = v_w + WIDE_BITS'(1);
				else if (down_hit && value > min_limit)
					cand = v_w - WIDE_BITS'(1);
			end
		end
	end

	// magnitude fits unsigned even for the most negative value
	assign mag = value[VALUE_BITS-1] ? VALUE_BITS'(-value) : VALUE_BITS'(value);

	// quotient estimate by ten from a shift-add series, low by at most one
	always_comb begin
		logic [VALUE_BITS-1:0] q;
		q = (mag >> 1) + (mag >> 2);
		for (int i = 2; i <= 5; i++) begin
			if ((1 << i) < VALUE_BITS)
				q = q + (q >> (1 << i));
		end
		q_est = q >> 3;
	end

	always_comb begin
		ctl.changed  = any_key;
		ctl.clamp_en = any_key && (mode == MODE_TYPED);
		ctl.use_div  = any_key && (mode == MODE_TYPED) && !minus_hit && erase_hit;
		ctl.neg      = value[VALUE_BITS-1];
	end

endmodule

// ----- rtl/core/kne_finish.sv -----
// kne_finish: quotient correction, result select and clamping to the limits
// depends on kne_pkg

module kne_finish #(
	parameter int VALUE_BITS = 32,
	parameter int WIDE_BITS  = 37
) (
	input  logic signed [WIDE_BITS-1:0]   cand,
	input  logic [VALUE_BITS-1:0]         mag,
	input  logic [VALUE_BITS-1:0]         q_est,
	input  kne_pkg::kne_ctl_t             ctl,
	input  logic signed [VALUE_BITS-1:0]  min_limit,
	input  logic signed [VALUE_BITS-1:0]  max_limit,
	output logic [VALUE_BITS-1:0]         result
);
	import kne_pkg::*;

	logic [VALUE_BITS+3:0] q10, rem;
	logic [VALUE_BITS-1:0] q_fix;
	logic signed [WIDE_BITS-1:0] div_w, pick, min_w, max_w, clamped;

	assign q10   = {1'b0, q_est, 3'b000} + {3'b000, q_est, 1'b0};
	assign rem   = {4'b0000, mag} - q10;
	// remainder stays below twenty, one step of correction
	assign q_fix = q_est + VALUE_BITS'(rem[4:0] > 5'd9);
	assign div_w = ctl.neg ? -$signed(WIDE_BITS'(q_fix)) : $signed(WIDE_BITS'(q_fix));

	assign pick  = ctl.use_div ? div_w : cand;
	assign min_w = WIDE_BITS'(min_limit);
	assign max_w = WIDE_BITS'(max_limit);

	// maximum tested first: with crossed limits a value above max_limit takes max_limit, any other takes min_limit
	always_comb begin
		clamped = pick;
		if (ctl.clamp_en) begin
			if (pick > max_w)
				clamped = max_w;
			else if (pick < min_w)
				clamped = min_w;
		end
	end

	assign result = clamped[VALUE_BITS-1:0];

endmodule

// ----- rtl/core/keypad_number_entry_editor.sv -----
// keypad_number_entry_editor: top level, stream ports and pipeline registers
// depends on kne_pkg, kne_cfg_regs, kne_decode, kne_finish
//
// usage
//   s_axis carries one key event per transaction: tdata holds clicked_keys
//   (bits 15:0) and current_value (next VALUE_BITS bits), tuser holds mode.
//   m_axis returns one result per event: tdata holds new_value zero-padded to
//   whole bytes, tuser holds the changed flag.
//   the cfg channel writes one register per transaction (index 0 min_limit,
//   1 max_limit, 2 minus, 3 erase, 4 up, 5 down key mask); cfg_ready is
//   always high and writes are expected only while the block is idle
// timing
//   m_axis_tvalid rises once the event has passed the input, decode and
//   output registers; throughput is one event per cycle while m_axis_tready
//   stays high, set by the three-stage pipeline
//   (input register, decode register, output register)
// reset and stall
//   arst_n clears all stage valids and loads the limits to the full signed
//   range and all key masks to zero; when m_axis_tready is low the stages
//   fill up one by one and s_axis_tready drops only when all three are full

module keypad_number_entry_editor #(
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [15:0] clicked_keys, [16 +: VALUE_BITS] current_value, zero-filled above
	input  logic [((16+VALUE_BITS+7)/8)*8-1:0]   s_axis_tdata,
	// [0] mode
	input  logic                                 s_axis_tuser,

	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [VALUE_BITS-1:0] new_value, zero-filled above
	output logic [((VALUE_BITS+7)/8)*8-1:0]      m_axis_tdata,
	// [0] changed
	output logic                                 m_axis_tuser,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [kne_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [(VALUE_BITS > 16 ? VALUE_BITS : 16)-1:0] cfg_data
);
	import kne_pkg::*;

	localparam int CFG_BITS  = VALUE_BITS > 16 ? VALUE_BITS : 16;
	localparam int WIDE_BITS = VALUE_BITS + 5; // holds v*10 +/- 9 and -v
	localparam int OUT_W     = ((VALUE_BITS+7)/8)*8;

	// configuration
	logic signed [VALUE_BITS-1:0] min_limit, max_limit;
	logic [KEY_W-1:0] minus_key_mask, erase_key_mask, up_key_mask, down_key_mask;

	kne_cfg_regs #(
		.VALUE_BITS (VALUE_BITS),
		.CFG_BITS   (CFG_BITS)
	) u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.min_limit      (min_limit),
		.max_limit      (max_limit),
		.minus_key_mask (minus_key_mask),
		.erase_key_mask (erase_key_mask),
		.up_key_mask    (up_key_mask),
		.down_key_mask  (down_key_mask)
	);

	// stage enables: a stage may load when it is empty or its contents move on
	logic valid_s1, valid_s2, valid_s3;
	logic free_s1, free_s2, free_s3;

	assign free_s3 = !valid_s3 || m_axis_tready;
	assign free_s2 = !valid_s2 || free_s3;
	assign free_s1 = !valid_s1 || free_s2;
	assign s_axis_tready = free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (free_s1) valid_s1 <= s_axis_tvalid;
			if (free_s2) valid_s2 <= valid_s1;
			if (free_s3) valid_s3 <= valid_s2;
		end
	end

	// stage 1: input register
	logic                         mode_s1;
	logic [KEY_W-1:0]             keys_s1;
	logic signed [VALUE_BITS-1:0] value_s1;

	always_ff @(posedge clk) begin
		if (free_s1 && s_axis_tvalid) begin
			mode_s1  <= s_axis_tuser;
			keys_s1  <= s_axis_tdata[KEY_W-1:0];
			value_s1 <= s_axis_tdata[KEY_W +: VALUE_BITS];
		end
	end

	// key decode, wide candidate and quotient estimate
	logic signed [WIDE_BITS-1:0] cand_d;
	logic [VALUE_BITS-1:0] mag_d, q_est_d;
	kne_ctl_t ctl_d;

	kne_decode #(
		.VALUE_BITS (VALUE_BITS),
		.WIDE_BITS  (WIDE_BITS)
	) u_decode (
		.mode           (mode_s1),
		.keys           (keys_s1),
		.value          (value_s1),
		.min_limit      (min_limit),
		.max_limit      (max_limit),
		.minus_key_mask (minus_key_mask),
		.erase_key_mask (erase_key_mask),
		.up_key_mask    (up_key_mask),
		.down_key_mask  (down_key_mask),
		.cand           (cand_d),
		.mag            (mag_d),
		.q_est          (q_est_d),
		.ctl            (ctl_d)
	);

	// stage 2: decode register
	logic signed [WIDE_BITS-1:0] cand_s2;
	logic [VALUE_BITS-1:0] mag_s2, q_est_s2;
	kne_ctl_t ctl_s2;

	always_ff @(posedge clk) begin
		if (free_s2 && valid_s1) begin
			cand_s2  <= cand_d;
			mag_s2   <= mag_d;
			q_est_s2 <= q_est_d;
			ctl_s2   <= ctl_d;
		end
	end

	// quotient fix-up, select and clamp
	logic [VALUE_BITS-1:0] result_f;

	kne_finish #(
		.VALUE_BITS (VALUE_BITS),
		.WIDE_BITS  (WIDE_BITS)
	) u_finish (
		.cand      (cand_s2),
		.mag       (mag_s2),
		.q_est     (q_est_s2),
		.ctl       (ctl_s2),
		.min_limit (min_limit),
		.max_limit (max_limit),
		.result    (result_f)
	);

	// stage 3: output register
	logic [VALUE_BITS-1:0] value_s3;
	logic                  changed_s3;

	always_ff @(posedge clk) begin
		if (free_s3 && valid_s2) begin
			value_s3   <= result_f;
			changed_s3 <= ctl_s2.changed;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = OUT_W'(value_s3);
	assign m_axis_tuser  = changed_s3;

	// a full pipeline with a stalled receiver must not take a new event
	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while pipeline is full and stalled");

	// an accepted event always lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted event lost at stage 1");

	// the quotient path is only chosen for typed, clamped results
	a_div_implies_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ctl_s2.use_div) |-> (ctl_s2.clamp_en && ctl_s2.changed))
		else $error("erase selected outside typed mode");

	// clamped results stay inside ordered limits
	a_clamp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(free_s3 && valid_s2 && ctl_s2.clamp_en && (min_limit <= max_limit))
		|=> (($signed(value_s3) >= min_limit) && ($signed(value_s3) <= max_limit)))
		else $error("clamped value outside limits");

	// a stalled result register holds its value
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !m_axis_tready) |=> (valid_s3 && $stable(value_s3)))
		else $error("result changed while stalled");

endmodule

// ----- dv/testbench.sv -----
// testbench: self-checking bench for the keypad number entry editor
// depends on kne_pkg and keypad_number_entry_editor; predicts every edit and checks each result
`timescale 1ns / 1ps

module testbench;
	import kne_pkg::*;

	localparam int VALUE_BITS   = 32;
	localparam int IN_DATA_W    = ((KEY_W + VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W   = ((VALUE_BITS + 7) / 8) * 8;
	localparam int CFG_DATA_W   = VALUE_BITS > 16 ? VALUE_BITS : 16;
	localparam int PIPE_LATENCY = 3;
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_PHASES    = 8;
	localparam int ITEMS_PER_PHASE  = 210;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [KEY_W-1:0] keys_t;

	typedef struct packed {
		value_t new_value;
		logic   changed;
	} edit_result_t;

	localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam value_t VALUE_MAX = ~VALUE_MIN;

	// key layout used by the directed tests: digits sit on bits 0..9
	localparam keys_t KEY_MINUS   = 16'h0400;
	localparam keys_t KEY_ERASE   = 16'h0800;
	localparam keys_t KEY_UP      = 16'h1000;
	localparam keys_t KEY_DOWN    = 16'h2000;
	localparam keys_t KEY_UNUSED  = 16'h8000;
	localparam keys_t KEY_DIGITS  = 16'h03FF;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [15:0] clicked_keys, [47:16] current_value
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	// [0] mode
	logic                  s_axis_tuser  = 1'b0;

	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b1;
	// [31:0] new_value
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// [0] changed
	logic                  m_axis_tuser;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// register shadow, kept in step with every accepted cfg transaction
	longint lo_limit   = longint'(VALUE_MIN);
	longint hi_limit   = longint'(VALUE_MAX);
	keys_t  minus_mask = '0;
	keys_t  erase_mask = '0;
	keys_t  up_mask    = '0;
	keys_t  down_mask  = '0;

	// edits still owed by the block, oldest first
	edit_result_t pending_edits[$];
	int mismatches = 0;

	// traffic shaping knobs
	int       burst_left    = 0;
	bit       steady_sender = 1'b0;
	bit [7:0] ready_pattern = 8'hFF;
	bit [2:0] ready_slot    = '0;

	keypad_number_entry_editor #(
		.VALUE_BITS(VALUE_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// receiver backpressure: walk an 8-slot ready pattern, one slot per cycle
	always @(negedge clk) begin
		ready_slot    <= ready_slot + 3'd1;
		m_axis_tready <= ready_pattern[ready_slot];
	end

	// expected edit for one key event, computed wide and then cut to the value width
	function automatic edit_result_t predict_edit(logic mode, keys_t keys, value_t cur);
		longint v;
		longint r;
		int digit;
		edit_result_t res;
		v = cur;
		r = v;
		digit = -1;
		if (keys != '0) begin
			if (mode == MODE_TYPED) begin
				if ((keys & minus_mask) != '0) begin
					r = -v;
				end else if ((keys & erase_mask) != '0) begin
					// truncation toward zero, magnitude under ten gives zero
					r = (v >= 10 || v <= -10) ? v / 10 : 0;
				end else begin
					// lowest of digits 1..9 wins, digit 0 only when none of them is clicked
					for (int d = int'(DIGIT_MAX); d >= 1; d--) begin
						if (keys[d]) digit = d;
					end
					if (digit < 0 && keys[0]) digit = 0;
					if (digit >= 0) r = (v < 0) ? v * 10 - digit : v * 10 + digit;
				end
				// max test first, so an inverted range still resolves the same way
				if (r > hi_limit) begin
					r = hi_limit;
				end else if (r < lo_limit) begin
					r = lo_limit;
				end
			end else if ((keys & up_mask) != '0 && v < hi_limit) begin
				r = v + 1;
			end else if ((keys & down_mask) != '0 && v > lo_limit) begin
				r = v - 1;
			end
		end
		res.new_value = value_t'(r);
		res.changed   = (keys != '0);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
		end
	endtask

	// result checker: every m_axis transaction against the oldest pending edit
	always @(posedge clk) begin
		edit_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_edits.size() == 0) begin
				report_mismatch("unexpected result", '0, m_axis_tdata);
			end else begin
				want = pending_edits.pop_front();
				if (m_axis_tdata[VALUE_BITS-1:0] !== want.new_value)
					report_mismatch("new_value", want.new_value, m_axis_tdata[VALUE_BITS-1:0]);
				if (m_axis_tuser !== want.changed)
					report_mismatch("changed", want.changed, m_axis_tuser);
			end
		end
	end

	// one key event: honor the burst/gap shaping, then hold until the transaction completes
	task automatic send_event(input logic mode, input keys_t keys, input value_t value);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady_sender ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= IN_DATA_W'({value, keys});
		do @(posedge clk); while (!s_axis_tready);
		pending_edits.push_back(predict_edit(mode, keys, value));
	endtask

	// stop sending and wait until every owed result has come back
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_edits.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_MIN_LIMIT:  lo_limit   = longint'($signed(data[VALUE_BITS-1:0]));
			REG_MAX_LIMIT:  hi_limit   = longint'($signed(data[VALUE_BITS-1:0]));
			REG_MINUS_MASK: minus_mask = data[KEY_W-1:0];
			REG_ERASE_MASK: erase_mask = data[KEY_W-1:0];
			REG_UP_MASK:    up_mask    = data[KEY_W-1:0];
			REG_DOWN_MASK:  down_mask  = data[KEY_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_limits(input value_t lo, input value_t hi);
		write_reg(REG_MIN_LIMIT, CFG_DATA_W'(lo));
		write_reg(REG_MAX_LIMIT, CFG_DATA_W'(hi));
	endtask

	task automatic write_masks(input keys_t minus, input keys_t erase, input keys_t up,
			input keys_t down);
		write_reg(REG_MINUS_MASK, CFG_DATA_W'(minus));
		write_reg(REG_ERASE_MASK, CFG_DATA_W'(erase));
		write_reg(REG_UP_MASK,    CFG_DATA_W'(up));
		write_reg(REG_DOWN_MASK,  CFG_DATA_W'(down));
	endtask

	// reset values: all masks clear, so only digits act in typed mode
	task automatic test_reset_defaults();
		send_event(MODE_TYPED, '0, value_t'(123));
		send_event(MODE_TYPED, 16'h0001, value_t'(123));
		send_event(MODE_TYPED, 16'h0200, VALUE_MAX);
		send_event(MODE_STEP,  16'hFFFF, VALUE_MIN);
		drain_results();
	endtask

	// key priority: minus over erase over digits 1..9 over digit 0
	task automatic test_key_priority();
		write_masks(KEY_MINUS, KEY_ERASE, KEY_UP, KEY_DOWN);
		send_event(MODE_TYPED, 16'hFFFF, value_t'(5));
		// negating the most negative value overflows and clamps to max
		send_event(MODE_TYPED, KEY_MINUS, VALUE_MIN);
		send_event(MODE_TYPED, KEY_ERASE | KEY_DIGITS, value_t'(-12345));
		send_event(MODE_TYPED, KEY_ERASE, value_t'(9));
		send_event(MODE_TYPED, KEY_ERASE, value_t'(-10));
		// appending past the value width clamps
		send_event(MODE_TYPED, 16'h0200, value_t'(214748364));
		// a clicked key with no action still flags a change
		send_event(MODE_TYPED, KEY_UNUSED, value_t'(42));
		for (int d = 0; d <= int'(DIGIT_MAX); d++) begin
			send_event(MODE_TYPED, keys_t'(1) << d, (d % 2) ? value_t'(-7 * d) : value_t'(31 * d));
		end
		drain_results();
	endtask

	task automatic test_step_mode();
		send_event(MODE_STEP, KEY_UP, VALUE_MAX);
		send_event(MODE_STEP, KEY_UP, value_t'(0));
		send_event(MODE_STEP, KEY_DOWN, VALUE_MIN);
		// up blocked at max, so down takes over
		send_event(MODE_STEP, KEY_UP | KEY_DOWN, VALUE_MAX);
		send_event(MODE_STEP, KEY_DOWN, value_t'(0));
		drain_results();
	endtask

	// narrow and inverted ranges
	task automatic test_limit_clamping();
		write_limits(value_t'(-100), value_t'(999));
		send_event(MODE_TYPED, KEY_UNUSED, value_t'(5000));
		send_event(MODE_TYPED, '0, value_t'(5000));
		send_event(MODE_STEP, KEY_UP, value_t'(-500));
		drain_results();
		write_limits(value_t'(50), value_t'(-50));
		send_event(MODE_TYPED, KEY_UNUSED, value_t'(100));
		send_event(MODE_TYPED, KEY_UNUSED, value_t'(-100));
		drain_results();
	endtask

	function automatic keys_t rand_mask();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 16'hFFFF;
			2: return keys_t'($urandom);
			default: return keys_t'(1) << $urandom_range(10, 15);
		endcase
	endfunction

	function automatic keys_t rand_keys();
		keys_t pick;
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2, 3: return keys_t'(1) << $urandom_range(0, KEY_W - 1);
			4, 5: begin
				case ($urandom_range(0, 3))
					0: pick = minus_mask;
					1: pick = erase_mask;
					2: pick = up_mask;
					default: pick = down_mask;
				endcase
				return (pick != '0) ? pick : keys_t'(1) << $urandom_range(0, 9);
			end
			6: return (keys_t'(1) << $urandom_range(0, KEY_W - 1)) |
				(keys_t'(1) << $urandom_range(0, KEY_W - 1));
			default: return keys_t'($urandom);
		endcase
	endfunction

	function automatic value_t rand_value();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
			1, 2: return value_t'(int'($urandom_range(0, 2000)) - 1000);
			3: return value_t'(lo_limit + longint'($urandom_range(0, 2)) - 1);
			4: return value_t'(hi_limit + longint'($urandom_range(0, 2)) - 1);
			// around the point where appending a digit leaves the value width
			5: return value_t'(($urandom_range(0, 1) ? 1 : -1) *
				(214748360 + int'($urandom_range(0, 9))));
			default: return value_t'($urandom);
		endcase
	endfunction

	// random phases, each with its own limits, masks and traffic shape
	task automatic test_random_traffic();
		value_t lo;
		value_t hi;
		value_t swap;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin lo = VALUE_MIN; hi = VALUE_MAX; end
				1: begin lo = value_t'(int'($urandom_range(0, 200)) - 100); hi = lo; end
				2: begin
					hi = value_t'(-int'($urandom_range(0, 1000)));
					lo = value_t'($urandom_range(1, 1000));
				end
				3: begin
					lo = value_t'(-int'($urandom_range(0, 5000)));
					hi = value_t'($urandom_range(0, 99999));
				end
				4: begin
					lo = value_t'($urandom);
					hi = value_t'($urandom);
					if (lo > hi) begin
						swap = lo;
						lo = hi;
						hi = swap;
					end
				end
				5: begin lo = VALUE_MIN; hi = value_t'($urandom); end
				6: begin lo = value_t'(-int'($urandom_range(0, 1000000))); hi = VALUE_MAX; end
				default: begin lo = VALUE_MAX; hi = VALUE_MIN; end
			endcase
			write_limits(lo, hi);
			write_masks(rand_mask(), rand_mask(), rand_mask(), rand_mask());
			// at least one ready slot per pattern so the receiver never stops for good
			ready_pattern = (p == 0) ? 8'hFF : (8'($urandom) | 8'h01);
			steady_sender = (p % 3 == 0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				send_event(($urandom_range(0, 3) == 0) ? MODE_STEP : MODE_TYPED,
					rand_keys(), rand_value());
				if ($urandom_range(0, 63) == 0)
					ready_pattern = $urandom_range(0, 2) == 0 ? 8'hFF :
						(8'($urandom) | 8'h01);
				// now and then let the pipeline run completely dry
				if ($urandom_range(0, 149) == 0)
					drain_results();
			end
			drain_results();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_key_priority();
		test_step_mode();
		test_limit_clamping();
		test_random_traffic();
		drain_results();
		repeat (4 * PIPE_LATENCY) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
